// ----- rtl/announce_peer_table_with_aging_unit_macros.svh -----
// Assertion macros for the announce peer table unit.
// Included by modules that carry concurrent assertions.
`ifndef ANNOUNCE_PEER_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define ANNOUNCE_PEER_TABLE_WITH_AGING_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define APT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define APT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ----- rtl/apt_pkg.sv -----
// Package for the announce peer table unit: types, codes, constants.
// No dependencies.
package apt_pkg;
    localparam int          TableEntriesDef = 16;
    localparam logic [31:0] MagicValue      = 32'h5344_5243;
    localparam logic [7:0]  VersionValue    = 8'd1;
    localparam logic [5:0]  PacketBytes     = 6'd39;
    localparam logic [31:0] StaleResetVal   = 32'd5000;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_LIST    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic [63:0] n3;
        logic [63:0] n2;
        logic [63:0] n1;
        logic [63:0] n0;
        logic [15:0] port;
        logic [7:0]  ver;
        logic [31:0] magic;
        logic [5:0]  len;
        logic [31:0] addr;
        logic [31:0] now;
        logic [1:0]  cmd;
    } item_t;

    typedef struct packed {
        logic        last;
        logic [63:0] n3;
        logic [63:0] n2;
        logic [63:0] n1;
        logic [63:0] n0;
        logic [31:0] seen;
        logic [15:0] port;
        logic [31:0] addr;
        logic [2:0]  status;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic clr_idx;   // rd and wr index to zero
        logic rd_inc;
        logic wr_inc;
        logic rd_issue;  // read entry at rd index
        logic copy;      // write read entry at wr index
        logic upd;       // write item at rd index (refresh)
        logic add;       // write item at count, count++
        logic set_cnt;   // count <= wr index
        logic clr_cnt;
        logic emit_blank;
        logic emit_full;
        logic emit_obs;  // emit stored item, status added/refreshed
        logic emit_list; // emit read entry
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic bad;
        logic rd_end;    // rd index == count
        logic match;     // read entry matches key (registered read)
        logic fresh;     // read entry not stale
        logic full;
        logic wr_zero;
        logic out_busy;  // output register holds a result that is not taken this cycle
        logic rd_last;   // rd index + 1 == count
    } sts_t;
endpackage

// ----- rtl/apt_datapath.sv -----
// Datapath of the announce peer table: table memory, index counters,
// output register. Depends on apt_pkg.
module apt_datapath #(
    parameter int TableEntries = apt_pkg::TableEntriesDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  apt_pkg::item_t     item,
    input  logic [31:0]        stale_limit,
    input  apt_pkg::ctl_t      ctl,
    output apt_pkg::sts_t      sts,
    output apt_pkg::result_t   res,
    output logic               res_valid,
    input  logic               res_ready
);
    import apt_pkg::*;
    localparam int IW = $clog2(TableEntries + 1);
    localparam int AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

    // entry layout: names [335:80], port [79:64], addr [63:32], seen [31:0]
    logic [335:0] mem [TableEntries];
    item_t        item_reg;
    logic [IW-1:0] cnt_reg, rd_reg, wr_reg;
    logic [335:0] rdata_reg;
    result_t      res_reg;
    logic         rv_reg;
    logic [IW-1:0] cnt_next, rd_next, wr_next;
    logic [335:0] wdata;
    logic [AW-1:0] waddr;
    logic         we;
    logic [31:0]  age;
    logic [63:0]  n3m;

    assign n3m = {8'h00, item_reg.n3[55:0]};
    assign age = item_reg.now - rdata_reg[31:0];

    always_comb
    begin
        we    = 1'b0;
        waddr = rd_reg[AW-1:0];
        wdata = {n3m, item_reg.n2, item_reg.n1, item_reg.n0,
                 item_reg.port, item_reg.addr, item_reg.now};
        if (ctl.copy)
        begin
            we    = 1'b1;
            waddr = wr_reg[AW-1:0];
            wdata = rdata_reg;
        end
        else if (ctl.upd)
        begin
            we = 1'b1;
        end
        else if (ctl.add)
        begin
            we    = 1'b1;
            waddr = cnt_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (ctl.rd_issue)
            rdata_reg <= mem[rd_reg[AW-1:0]];
        if (ctl.load)
            item_reg <= item;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.clr_cnt)
            cnt_next = '0;
        else if (ctl.set_cnt)
            cnt_next = wr_reg;
        else if (ctl.add)
            cnt_next = cnt_reg + IW'(1);
        rd_next = ctl.clr_idx ? '0 : (ctl.rd_inc ? rd_reg + IW'(1) : rd_reg);
        wr_next = ctl.clr_idx ? '0 : (ctl.wr_inc ? wr_reg + IW'(1) : wr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
            wr_reg  <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            if (ctl.emit_blank || ctl.emit_full || ctl.emit_obs || ctl.emit_list)
                rv_reg <= 1'b1;
            else if (res_ready)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_blank || ctl.emit_full)
        begin
            res_reg <= {1'b1, 256'b0, 32'b0,
                        ctl.emit_full ? item_reg.port : 16'b0,
                        ctl.emit_full ? item_reg.addr : 32'b0,
                        ctl.emit_full ? ST_FULL
                                      : (item_reg.cmd == CMD_OBSERVE ? ST_REJECTED
                                                                     : ST_EMPTY)};
        end
        else if (ctl.emit_obs)
        begin
            res_reg <= {1'b1, n3m, item_reg.n2, item_reg.n1, item_reg.n0, item_reg.now,
                        item_reg.port, item_reg.addr, ctl.add ? ST_ADDED : ST_REFRESHED};
        end
        else if (ctl.emit_list)
        begin
            res_reg <= {(rd_reg + IW'(1) == cnt_reg), rdata_reg[335:80], rdata_reg[31:0],
                        rdata_reg[79:64], rdata_reg[63:32], ST_ENTRY};
        end
    end

    assign sts.cmd      = cmd_t'(item_reg.cmd);
    assign sts.bad      = item_reg.len != PacketBytes || item_reg.magic != MagicValue
                          || item_reg.ver != VersionValue;
    assign sts.rd_end   = rd_reg == cnt_reg;
    assign sts.match    = rdata_reg[63:32] == item_reg.addr && rdata_reg[79:64] == item_reg.port;
    assign sts.fresh    = !(age > stale_limit);
    assign sts.full     = cnt_reg == IW'(TableEntries);
    assign sts.wr_zero  = wr_reg == '0;
    assign sts.out_busy = rv_reg && !res_ready;
    assign sts.rd_last  = rd_reg + IW'(1) == cnt_reg;

    assign res       = res_reg;
    assign res_valid = rv_reg;

    `include "announce_peer_table_with_aging_unit_macros.svh"
    `APT_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= IW'(TableEntries))
    `APT_ASSERT_IMP(a_wr_le_rd, clk, rst_n, ctl.copy, wr_reg <= rd_reg)
    `APT_ASSERT_NXT(a_hold, clk, rst_n, rv_reg && !res_ready, rv_reg && $stable(res_reg))
endmodule

// ----- rtl/apt_ctrl.sv -----
// Controller state machine of the announce peer table.
// Depends on apt_pkg.
module apt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    output logic          in_ready,
    input  apt_pkg::sts_t sts,
    output apt_pkg::ctl_t ctl
);
    import apt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SRD   = 8'b0000_0100,
        S_SCHK  = 8'b0000_1000,
        S_CRD   = 8'b0001_0000,
        S_CCHK  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_ERD   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !sts.out_busy;
                if (in_fire)
                begin
                    ctl.load    = 1'b1;
                    ctl.clr_idx = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_OBSERVE:
                    begin
                        if (sts.bad)
                        begin
                            ctl.emit_blank = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                            state_next = S_SRD;
                    end
                    CMD_LIST:  state_next = S_CRD;
                    CMD_CLEAR:
                    begin
                        ctl.clr_cnt    = 1'b1;
                        ctl.emit_blank = 1'b1;
                        state_next     = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SRD:
            begin
                if (sts.rd_end)
                begin
                    if (sts.full)
                        ctl.emit_full = 1'b1;
                    else
                    begin
                        ctl.add      = 1'b1;
                        ctl.emit_obs = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (sts.match)
                begin
                    ctl.upd      = 1'b1;
                    ctl.emit_obs = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ctl.rd_inc = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_CRD:
            begin
                if (sts.rd_end)
                begin
                    ctl.set_cnt = 1'b1;
                    if (sts.wr_zero)
                    begin
                        ctl.emit_blank = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ctl.clr_idx = 1'b1;
                        state_next  = S_ERD;
                    end
                end
                else
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_CCHK;
                end
            end
            S_CCHK:
            begin
                ctl.rd_inc = 1'b1;
                if (sts.fresh)
                begin
                    ctl.copy   = 1'b1;
                    ctl.wr_inc = 1'b1;
                end
                state_next = S_CRD;
            end
            S_ERD:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.emit_list = 1'b1;
                    ctl.rd_inc    = 1'b1;
                    state_next    = sts.rd_last ? S_IDLE : S_ERD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `include "announce_peer_table_with_aging_unit_macros.svh"
    `APT_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `APT_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `APT_ASSERT_IMP(a_no_wr_clash, clk, rst_n, 1'b1, $onehot0({ctl.copy, ctl.upd, ctl.add}))
endmodule

// ----- rtl/announce_peer_table_with_aging_unit.sv -----
// Announce peer table with aging: sequential table of peers keyed by
// address and port. Top level; depends on apt_pkg, apt_ctrl, apt_datapath.
//
// s_axis carries one command transaction; m_axis returns its results, tlast
// on the final one. cfg writes stale_limit; the user must do so only while the
// unit is idle, as the block itself does not enforce it. One item at a time.
// Observe searches the table entry by entry (one memory read port). List
// sweeps every entry for aging, then emits each survivor, as the single
// read port is shared.
// A result sits in an output register until m_axis_tready; while it is held,
// listing pauses and no new transaction is accepted.
// Reset empties the table and sets stale_limit to 5000; no clearing pass.
module announce_peer_table_with_aging_unit #(
    parameter int TableEntries = apt_pkg::TableEntriesDef
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, now, addr, len, magic, ver, port, name0..3 (low first; 384b)
    input  logic [383:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, entry_address, entry_port, entry_seen, entry_name0..3 (low first)
    output logic [343:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import apt_pkg::*;

    item_t   item;
    result_t res;
    ctl_t    ctl;
    sts_t    sts;
    logic    in_fire;
    logic [31:0] stale_reg;

    assign item.cmd   = s_axis_tdata[1:0];
    assign item.now   = s_axis_tdata[33:2];
    assign item.addr  = s_axis_tdata[65:34];
    assign item.len   = s_axis_tdata[71:66];
    assign item.magic = s_axis_tdata[103:72];
    assign item.ver   = s_axis_tdata[111:104];
    assign item.port  = s_axis_tdata[127:112];
    assign item.n0    = s_axis_tdata[191:128];
    assign item.n1    = s_axis_tdata[255:192];
    assign item.n2    = s_axis_tdata[319:256];
    assign item.n3    = s_axis_tdata[383:320];

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stale_reg <= StaleResetVal;
        else if (cfg_valid)
            stale_reg <= cfg_data;
    end

    apt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    apt_datapath #(.TableEntries(TableEntries)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .stale_limit (stale_reg),
        .ctl         (ctl),
        .sts         (sts),
        .res         (res),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, res.n3, res.n2, res.n1, res.n0, res.seen, res.port,
                           res.addr, res.status};
    assign m_axis_tlast = res.last;
endmodule

// ----- dv/announce_peer_table_with_aging_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for announce_peer_table_with_aging_unit.
// Depends on apt_pkg; predicts table contents, aging and listing in-bench.
module announce_peer_table_with_aging_unit_tb;
    import apt_pkg::*;

    localparam int          Depth    = 16;
    localparam logic [63:0] NameMask = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] seen;
        logic [63:0] name [4];
        logic        last;
    } peer_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [343:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    announce_peer_table_with_aging_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // table mirror
    logic [31:0] tbl_addr [Depth];
    logic [15:0] tbl_port [Depth];
    logic [31:0] tbl_seen [Depth];
    logic [63:0] tbl_name [Depth][4];
    int          tbl_count;
    logic [31:0] stale_lim;

    peer_result_t pending_results [$];
    int  error_count;
    int  item_count;
    int  result_count;
    int  cfg_count;
    bit  quiet;
    logic [31:0] tick;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    function automatic item_t make_item(cmd_t cmd, logic [31:0] now, logic [31:0] addr,
                                        logic [15:0] port, logic [63:0] n0, logic [63:0] n1,
                                        logic [63:0] n2, logic [63:0] n3,
                                        logic [5:0] len = PacketBytes,
                                        logic [31:0] magic = MagicValue,
                                        logic [7:0] ver = VersionValue);
        item_t it;
        it.cmd   = cmd;
        it.len   = len;
        it.magic = magic;
        it.ver   = ver;
        it.now   = now;
        it.addr  = addr;
        it.port  = port;
        it.n0    = n0;
        it.n1    = n1;
        it.n2    = n2;
        it.n3    = n3;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic peer_result_t blank_result(status_t st);
        peer_result_t r;
        r.status = st;
        r.addr   = '0;
        r.port   = '0;
        r.seen   = '0;
        for (int k = 0; k < 4; k++) r.name[k] = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic peer_result_t entry_result(status_t st, int i, logic last);
        peer_result_t r;
        r.status = st;
        r.addr   = tbl_addr[i];
        r.port   = tbl_port[i];
        r.seen   = tbl_seen[i];
        for (int k = 0; k < 4; k++) r.name[k] = tbl_name[i][k];
        r.last   = last;
        return r;
    endfunction

    task automatic queue_result(peer_result_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic predict_table(item_t it);
        int i;
        int n;
        peer_result_t r;
        case (it.cmd)
            CMD_OBSERVE: begin
                if (it.len != PacketBytes || it.magic != MagicValue || it.ver != VersionValue)
                begin
                    queue_result(blank_result(ST_REJECTED));
                end
                else begin
                    for (i = 0; i < tbl_count; i++)
                        if (tbl_addr[i] == it.addr && tbl_port[i] == it.port) break;
                    if (i == tbl_count && tbl_count >= Depth) begin
                        r = blank_result(ST_FULL);
                        r.addr = it.addr;
                        r.port = it.port;
                        queue_result(r);
                    end
                    else begin
                        n = (i == tbl_count);
                        if (n) begin
                            tbl_addr[i] = it.addr;
                            tbl_port[i] = it.port;
                            tbl_count++;
                        end
                        tbl_seen[i]    = it.now;
                        tbl_name[i][0] = it.n0;
                        tbl_name[i][1] = it.n1;
                        tbl_name[i][2] = it.n2;
                        tbl_name[i][3] = it.n3 & NameMask;
                        queue_result(entry_result(n ? ST_ADDED : ST_REFRESHED, i, 1'b1));
                    end
                end
            end
            CMD_LIST: begin
                n = 0;
                for (i = 0; i < tbl_count; i++) begin
                    if (32'(it.now - tbl_seen[i]) > stale_lim) continue;
                    tbl_addr[n] = tbl_addr[i];
                    tbl_port[n] = tbl_port[i];
                    tbl_seen[n] = tbl_seen[i];
                    for (int k = 0; k < 4; k++) tbl_name[n][k] = tbl_name[i][k];
                    n++;
                end
                tbl_count = n;
                if (n == 0) queue_result(blank_result(ST_EMPTY));
                for (i = 0; i < n; i++)
                    queue_result(entry_result(ST_ENTRY, i, i + 1 == n));
            end
            CMD_CLEAR: begin
                tbl_count = 0;
                queue_result(blank_result(ST_EMPTY));
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // result checker
    initial begin
        peer_result_t want;
        logic [63:0]  got_name;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", 64'(m_axis_tdata[2:0]),
                                    64'd0);
                end
                else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[2:0] !== want.status)
                        report_mismatch("status", 64'(m_axis_tdata[2:0]),
                                        64'(want.status));
                    if (m_axis_tdata[34:3] !== want.addr)
                        report_mismatch("entry_address", 64'(m_axis_tdata[34:3]),
                                        64'(want.addr));
                    if (m_axis_tdata[50:35] !== want.port)
                        report_mismatch("entry_port", 64'(m_axis_tdata[50:35]),
                                        64'(want.port));
                    if (m_axis_tdata[82:51] !== want.seen)
                        report_mismatch("entry_seen", 64'(m_axis_tdata[82:51]),
                                        64'(want.seen));
                    for (int k = 0; k < 4; k++) begin
                        got_name = m_axis_tdata[83 + 64 * k +: 64];
                        if (got_name !== want.name[k])
                            report_mismatch($sformatf("entry_name%0d", k), got_name,
                                            want.name[k]);
                    end
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", 64'(m_axis_tlast), 64'(want.last));
                end
            end
        end
    end

    // result-side backpressure
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    task automatic send_item(item_t it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        do @(posedge clk); while (!s_axis_tready);
        item_count++;
        predict_table(it);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_stale_limit(logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        stale_lim = value;
        cfg_count++;
    endtask

    task automatic send_observe(logic [31:0] now, logic [31:0] addr, logic [15:0] port);
        send_item(make_item(CMD_OBSERVE, now, addr, port, rand64(), rand64(), rand64(),
                            rand64()));
    endtask

    task automatic send_cmd(cmd_t cmd, logic [31:0] now);
        send_item(make_item(cmd, now, $urandom, 16'($urandom), rand64(), rand64(), rand64(),
                            rand64(), 6'($urandom), $urandom, 8'($urandom)));
    endtask

    task automatic test_reject();
        send_item(make_item(CMD_OBSERVE, 100, 32'hFFFF_FFFF, 16'hFFFF, '1, '1, '1, '1, 6'd0));
        send_item(make_item(CMD_OBSERVE, 100, 1, 16'd2, '1, '1, '1, '1, 6'd55));
        send_item(make_item(CMD_OBSERVE, 100, 1, 16'd2, '1, '1, '1, '1, PacketBytes,
                            MagicValue ^ 32'h0100_0000));
        send_item(make_item(CMD_OBSERVE, 100, 1, 16'd2, '1, '1, '1, '1, PacketBytes,
                            MagicValue, 8'd0));
        send_item(make_item(CMD_OBSERVE, 100, 1, 16'd2, '1, '1, '1, '1, PacketBytes,
                            MagicValue, 8'hFF));
    endtask

    task automatic test_add_refresh();
        send_item(make_item(CMD_OBSERVE, 200, 32'hFFFF_FFFF, 16'hFFFF, '1, '1, '1, '1));
        send_item(make_item(CMD_OBSERVE, 210, 0, 16'd0, '0, '0, '0, '0));
        send_item(make_item(CMD_OBSERVE, 220, 32'hFFFF_FFFF, 16'hFFFF, rand64(), rand64(),
                            rand64(), '1));
        send_observe(230, 32'hFFFF_FFFF, 16'h0000);
        send_cmd(CMD_LIST, 240);
    endtask

    task automatic test_aging_list();
        send_observe(20000, 32'h0A00_0001, 16'd80);
        send_cmd(CMD_LIST, 20000 + StaleResetVal);
        send_cmd(CMD_LIST, 20001 + StaleResetVal);
        send_cmd(CMD_LIST, 20002 + StaleResetVal);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < Depth; i++) send_observe(30000, $urandom, 16'(i));
        send_observe(30001, 32'hC0A8_0001, 16'h1234);
        send_cmd(CMD_LIST, 30002);
    endtask

    task automatic test_clear_and_ignore();
        send_cmd(CMD_NONE, 30003);
        send_cmd(CMD_CLEAR, 30004);
        send_cmd(CMD_LIST, 30005);
        drain_results();
    endtask

    task automatic test_random(int count);
        int r;
        logic [31:0] pool [6];
        for (int k = 0; k < 6; k++) pool[k] = $urandom;
        for (int n = 0; n < count; n++) begin
            tick += $urandom_range(0, 2500);
            r = $urandom_range(0, 99);
            if (r < 60)
                send_observe(tick, pool[$urandom_range(0, 5)], 16'($urandom_range(0, 2)));
            else if (r < 68)
                send_observe(tick, $urandom, 16'($urandom));
            else if (r < 78)
                send_item(make_item(CMD_OBSERVE, tick, $urandom, 16'($urandom), rand64(),
                                    rand64(), rand64(), rand64(),
                                    $urandom_range(0, 2) == 0 ? PacketBytes
                                                              : 6'($urandom_range(0, 55)),
                                    $urandom_range(0, 2) == 0 ? MagicValue : 32'($urandom),
                                    $urandom_range(0, 2) == 0 ? VersionValue : 8'($urandom)));
            else if (r < 92)
                send_cmd(CMD_LIST, tick);
            else if (r < 96)
                send_cmd(CMD_CLEAR, tick);
            else
                send_cmd(CMD_NONE, tick);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        tbl_count     = 0;
        stale_lim     = StaleResetVal;
        error_count   = 0;
        item_count    = 0;
        result_count  = 0;
        cfg_count     = 0;
        quiet         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reject();
        test_add_refresh();
        test_aging_list();
        test_table_full();
        test_clear_and_ignore();

        tick = 32'hFFFF_E000;
        write_stale_limit(32'hFFFF_FFFF);
        test_random(70);
        write_stale_limit(32'd0);
        test_random(50);
        write_stale_limit(32'($urandom_range(1000, 8000)));
        test_random(60);
        write_stale_limit(StaleResetVal);
        test_random(50);
        quiet = 1'b1;
        test_random(60);

        drain_results();
        $display("covered %0d transactions in, %0d results out, %0d stale_limit writes",
                 item_count, result_count, cfg_count);
        $display("reject, add, refresh, full table, aging, wrap, clear and ignored commands");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
